@@ design/suq_pkg.sv @@
package suq_pkg;

  // Default number of entries held by the queue
  localparam int DEFAULT_CAPACITY = 128;

  // Operation codes carried on the op field
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  // Result status codes
  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_POPPED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  // Command broadcast to every cell of the row
  typedef struct packed {
    logic capture;    // compare the incoming value against the held entry
    logic shift_in;   // open a slot and place the key at its sorted position
    logic shift_out;  // drop the head and move every entry one cell down
  } suq_cmd_t;

endpackage

@@ design/suq_cell.sv @@
module suq_cell
  import suq_pkg::*;
#(
  parameter int IDX = 0,
  parameter int CW  = 8
) (
  input  logic               clk,
  input  suq_cmd_t           cmd,
  input  logic [CW-1:0]      count,
  input  logic signed [31:0] probe,
  input  logic signed [31:0] key,
  input  logic signed [31:0] prev_entry,
  input  logic               prev_lt,
  input  logic signed [31:0] next_entry,
  output logic signed [31:0] entry,
  output logic               lt,
  output logic               eq
);

  logic live;

  // Cell holds a live entry when its position is below the fill count
  assign live = (CW'(IDX) < count);

  // Record how the held entry compares to the incoming value
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      lt <= live && (entry < probe);
      eq <= live && (entry == probe);
    end
  end

  // Keep, take the key, take from the left neighbor, or take from the right
  always_ff @(posedge clk) begin
    if (cmd.shift_in) begin
      if (!lt) begin
        entry <= prev_lt ? key : prev_entry;
      end
    end else if (cmd.shift_out) begin
      entry <= next_entry;
    end
  end

endmodule

@@ design/sorted_unique_priority_queue_core.sv @@
// Sorted unique min priority queue.
// Input channel (in_valid/in_ready): op selects insert (value placed in sorted
// order) or pop (smallest value removed). Output channel (out_valid/out_ready)
// returns one transaction per input: status, popped_value (zero unless popped)
// and entry_count, the number of live entries after the operation.
// Entries sit in a row of CAPACITY cells in ascending order. At acceptance
// every cell compares its entry with the value; in the S_APPLY state the
// duplicate and full checks resolve and, once the result register is free,
// the cells from the insert position up (every cell on a pop) shift one
// place in step with their neighbors. The next item is taken only after
// that shift, back in S_IDLE, and may be taken while a result waits.
// If the receiver stalls, the result holds in the output register; a second
// finished item waits in the shift cycle until the register frees up.
// Reset empties the queue (fill count cleared, no result pending); the cell
// contents are not cleared and are read only below the fill count.
module sorted_unique_priority_queue_core
  import suq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               op,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         status,
  output logic signed [31:0] popped_value,
  output logic [7:0]         entry_count
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_APPLY = 2'b10
  } state_t;

  state_t             state, state_next;
  logic               op_q;
  logic signed [31:0] key;
  logic [CW-1:0]      count, count_next;
  status_t            res_status;
  suq_cmd_t           cmd;
  logic               accept, fire, dup;

  logic signed [31:0] entry_vec [CAPACITY];
  logic [CAPACITY-1:0] lt_vec, eq_vec;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign fire     = (state == S_APPLY) && (!out_valid || out_ready);
  assign dup      = |eq_vec;

  // Resolve the outcome from the registered compare flags
  always_comb begin
    if (op_q == OP_POP) begin
      res_status = (count == '0) ? ST_EMPTY : ST_POPPED;
    end else if (dup) begin
      res_status = ST_DUPLICATE;
    end else if (count == CW'(CAPACITY)) begin
      res_status = ST_FULL;
    end else begin
      res_status = ST_INSERTED;
    end
  end

  assign cmd.capture   = accept;
  assign cmd.shift_in  = fire && (res_status == ST_INSERTED);
  assign cmd.shift_out = fire && (res_status == ST_POPPED);

  always_comb begin
    count_next = count;
    if (cmd.shift_in) begin
      count_next = count + 1'b1;
    end else if (cmd.shift_out) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (accept) state_next = S_APPLY;
      S_APPLY: if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold the operation for the shift cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q <= op;
      key  <= value;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (fire) begin
      status       <= res_status;
      popped_value <= (res_status == ST_POPPED) ? entry_vec[0] : '0;
      entry_count  <= 8'(count_next);
    end
  end

  // Row of cells, each linked to its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [31:0] prev_e, next_e;
    logic               prev_l;
    if (i == 0) begin : g_head
      assign prev_e = key;
      assign prev_l = 1'b1;
    end else begin : g_mid
      assign prev_e = entry_vec[i-1];
      assign prev_l = lt_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_body
      assign next_e = entry_vec[i+1];
    end
    suq_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count),
      .probe      (value),
      .key        (key),
      .prev_entry (prev_e),
      .prev_lt    (prev_l),
      .next_entry (next_e),
      .entry      (entry_vec[i]),
      .lt         (lt_vec[i]),
      .eq         (eq_vec[i])
    );
  end

endmodule

@@ design/suq_checker.sv @@
module suq_checker
  import suq_pkg::*;
#(
  parameter int CAPACITY = DEFAULT_CAPACITY
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         status,
  input logic signed [31:0] popped_value,
  input logic [7:0]         entry_count
);

  // An accepted transaction closes the input for the shift cycle
  a_in_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken in the shift cycle");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(popped_value))
    else $error("result changed while stalled");

  // Only a pop transaction carries a value
  a_popped_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_POPPED) |-> popped_value == '0)
    else $error("nonzero popped_value without pop");

  // An empty report leaves nothing behind
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_EMPTY) |-> entry_count == '0)
    else $error("empty reported with live entries");

  // A full drop only happens at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> entry_count == 8'(CAPACITY))
    else $error("full reported below capacity");

endmodule

bind sorted_unique_priority_queue_core suq_checker #(
  .CAPACITY (CAPACITY)
) u_suq_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .status       (status),
  .popped_value (popped_value),
  .entry_count  (entry_count)
);

@@ dv/sorted_unique_priority_queue_core_tb.sv @@
`timescale 1ns / 100ps

module sorted_unique_priority_queue_core_tb;
  import suq_pkg::*;

  localparam int CAP          = DEFAULT_CAPACITY;
  localparam int DIRECTED_LEN = 21;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_AT      = DIRECTED_LEN + 40;
  localparam int HOLD_CYCLES  = 300;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] popped;
    logic [7:0]         entries;
  } queue_result_t;

  typedef struct packed {
    logic               op;
    logic signed [31:0] value;
    logic               typed;
    queue_result_t      res;
  } stim_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic               op;
  logic signed [31:0] value;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         status;
  logic signed [31:0] popped_value;
  logic [7:0]         entry_count;

  // Predictor state: live entries in ascending order
  logic signed [31:0] model_entries[$];
  queue_result_t      pending_results[$];
  stim_row_t          directed_rows[DIRECTED_LEN];

  int sent_count     = 0;
  int burst_left     = 0;
  int mismatch_count = 0;

  // Receiver pattern state
  int rx_mode      = 0;
  int rx_mode_left = 0;
  int hold_left    = 0;
  bit hold_done    = 1'b0;

  sorted_unique_priority_queue_core #(
    .CAPACITY(CAP)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .value        (value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .popped_value (popped_value),
    .entry_count  (entry_count)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one operation to the sorted list and return the result it yields
  function automatic queue_result_t apply_queue_op(input logic op_i,
                                                   input logic signed [31:0] val_i);
    queue_result_t r;
    int            pos;
    r.popped = '0;
    if (op_i == OP_INSERT) begin
      pos = 0;
      while (pos < model_entries.size() && model_entries[pos] < val_i) pos++;
      if (pos < model_entries.size() && model_entries[pos] == val_i) begin
        r.status = ST_DUPLICATE;
      end else if (model_entries.size() >= CAP) begin
        r.status = ST_FULL;
      end else begin
        model_entries.insert(pos, val_i);
        r.status = ST_INSERTED;
      end
    end else if (model_entries.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.popped = model_entries.pop_front();
      r.status = ST_POPPED;
    end
    r.entries = 8'(model_entries.size());
    return r;
  endfunction

  // Mix of narrow range (duplicates), extremes, held values and full-width values
  function automatic logic signed [31:0] pick_value();
    int unsigned sel;
    logic signed [31:0] v;
    sel = $urandom_range(0, 9);
    if (sel <= 3) begin
      v = int'($urandom_range(0, 299)) - 150;
    end else if (sel <= 5) begin
      v = $urandom;
    end else if (sel == 6) begin
      case ($urandom_range(0, 3))
        0:       v = 32'sh7FFFFFFF;
        1:       v = 32'sh80000000;
        2:       v = 32'sh00000000;
        default: v = 32'shFFFFFFFF;
      endcase
    end else if (model_entries.size() > 0) begin
      v = model_entries[$urandom_range(0, model_entries.size() - 1)];
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  // Offer one transaction, wait for acceptance, record its expected result
  task automatic send_item(input logic op_i, input logic signed [31:0] val_i,
                           input logic typed, input queue_result_t typed_res);
    queue_result_t predicted;
    int            gap;
    in_valid <= 1'b1;
    op       <= op_i;
    value    <= val_i;
    do @(posedge clk); while (!in_ready);
    predicted = apply_queue_op(op_i, val_i);
    if (typed) predicted = typed_res;
    pending_results.push_back(predicted);
    sent_count++;
    // End of burst: insert a random gap before the next one
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver: random ready pattern, plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!hold_done && sent_count >= HOLD_AT) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= $urandom_range(0, 2);
        rx_mode_left <= $urandom_range(16, 120);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Compare each output transaction with the oldest expectation
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: status %0d popped %0d entries %0d",
                   status, popped_value, entry_count);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status || popped_value !== want.popped ||
            entry_count !== want.entries) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected status %0d popped %0d entries %0d, got %0d %0d %0d",
                     want.status, want.popped, want.entries,
                     status, popped_value, entry_count);
        end
      end
    end
  end

  // Main sequence: reset, directed table, random phases, drain
  initial begin
    int i;
    int phase_len;
    int insert_pct;
    int mixed_sent;
    rst      = 1'b1;
    in_valid = 1'b0;
    op       = OP_INSERT;
    value    = '0;

    // Extremes, duplicates, ordering across sign, empty pops
    directed_rows[0]  = '{OP_POP,    32'sd0,        1'b1, '{ST_EMPTY,     32'sd0, 8'd0}};
    directed_rows[1]  = '{OP_INSERT, 32'sh7FFFFFFF, 1'b1, '{ST_INSERTED,  32'sd0, 8'd1}};
    directed_rows[2]  = '{OP_INSERT, 32'sh80000000, 1'b1, '{ST_INSERTED,  32'sd0, 8'd2}};
    directed_rows[3]  = '{OP_INSERT, 32'sh7FFFFFFF, 1'b1, '{ST_DUPLICATE, 32'sd0, 8'd2}};
    directed_rows[4]  = '{OP_INSERT, 32'shFFFFFFFF, 1'b1, '{ST_INSERTED,  32'sd0, 8'd3}};
    directed_rows[5]  = '{OP_INSERT, 32'sd0,        1'b1, '{ST_INSERTED,  32'sd0, 8'd4}};
    directed_rows[6]  = '{OP_INSERT, 32'sd1,        1'b1, '{ST_INSERTED,  32'sd0, 8'd5}};
    directed_rows[7]  = '{OP_INSERT, 32'sh80000000, 1'b1, '{ST_DUPLICATE, 32'sd0, 8'd5}};
    directed_rows[8]  = '{OP_INSERT, 32'shFFFFFFFF, 1'b1, '{ST_DUPLICATE, 32'sd0, 8'd5}};
    directed_rows[9]  = '{OP_POP,    32'sd0,        1'b1, '{ST_POPPED, 32'sh80000000, 8'd4}};
    directed_rows[10] = '{OP_POP,    32'sd0,        1'b1, '{ST_POPPED, 32'shFFFFFFFF, 8'd3}};
    directed_rows[11] = '{OP_INSERT, 32'sh55555555, 1'b0, '0};
    directed_rows[12] = '{OP_INSERT, 32'shAAAAAAAA, 1'b0, '0};
    directed_rows[13] = '{OP_POP,    32'sh12345678, 1'b0, '0};
    directed_rows[14] = '{OP_POP,    32'sd0,        1'b0, '0};
    directed_rows[15] = '{OP_POP,    32'sd0,        1'b0, '0};
    directed_rows[16] = '{OP_POP,    32'sd0,        1'b0, '0};
    directed_rows[17] = '{OP_POP,    32'sd0,        1'b0, '0};
    directed_rows[18] = '{OP_POP,    32'shFFFFFFFF, 1'b1, '{ST_EMPTY,     32'sd0, 8'd0}};
    directed_rows[19] = '{OP_INSERT, 32'sd0,        1'b0, '0};
    directed_rows[20] = '{OP_POP,    32'sd0,        1'b0, '0};

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < DIRECTED_LEN; i++)
      send_item(directed_rows[i].op, directed_rows[i].value,
                directed_rows[i].typed, directed_rows[i].res);

    // Fill to capacity, mostly inserts of fresh full-width values
    while (model_entries.size() < CAP) begin
      if ($urandom_range(0, 9) == 0) send_item(OP_POP, $urandom, 1'b0, '0);
      else if ($urandom_range(0, 3) == 0) send_item(OP_INSERT, pick_value(), 1'b0, '0);
      else send_item(OP_INSERT, $urandom, 1'b0, '0);
    end

    // Hit the full queue with held values (duplicate wins) and new ones (dropped)
    for (i = 0; i < 16; i++) begin
      if (i % 2 == 0)
        send_item(OP_INSERT, model_entries[$urandom_range(0, model_entries.size() - 1)],
                  1'b0, '0);
      else
        send_item(OP_INSERT, $urandom, 1'b0, '0);
    end

    // Drain to empty, then pop past the bottom
    while (model_entries.size() > 0) begin
      if ($urandom_range(0, 99) < 95) send_item(OP_POP, $urandom, 1'b0, '0);
      else send_item(OP_INSERT, pick_value(), 1'b0, '0);
    end
    repeat (3) send_item(OP_POP, $urandom, 1'b0, '0);

    // Mixed phases with varying insert/pop balance
    mixed_sent = 0;
    while (mixed_sent < 40 || sent_count < RANDOM_ITEMS) begin
      phase_len  = $urandom_range(10, 60);
      insert_pct = $urandom_range(20, 80);
      repeat (phase_len) begin
        if ($urandom_range(0, 99) < insert_pct) send_item(OP_INSERT, pick_value(), 1'b0, '0);
        else send_item(OP_POP, $urandom, 1'b0, '0);
        mixed_sent++;
      end
    end
    in_valid <= 1'b0;

    // Wait out the remaining results
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
